>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the spherical rotation RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SCR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scr assertion failed");

// Next-cycle implication, switched off while reset is held.
`define SCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scr assertion failed");

`endif

>>> hw/rtl/scr_pkg.sv
// Package for the spherical coordinate rotation core: payload types,
// register indexes, number formats and the arctangent table function.
// No dependencies.
package scr_pkg;

  localparam int SCR_ANGLE_BITS    = 32;
  localparam int SCR_CORDIC_STAGES = 30;
  localparam int SCR_QW            = 36;   // signed Q30 working width
  localparam int SCR_FRAC          = 30;
  localparam int SCR_CFG_IW        = 3;
  localparam logic signed [SCR_QW-1:0] SCR_KINV  = SCR_QW'(652032874);
  localparam logic signed [SCR_QW-1:0] SCR_ONE_Q = SCR_QW'(1073741824);
  localparam logic [63:0] SCR_EIGHTH_TURN = 64'h2000000000000000;
  localparam logic [63:0] SCR_TWO_OVER_PI = 64'hA2F9836E4E441529;

  typedef struct packed {
    logic        [31:0] in_longitude;
    logic signed [31:0] in_latitude;
  } scr_in_t;

  typedef struct packed {
    logic        [31:0] out_longitude;
    logic signed [31:0] out_latitude;
    logic               degenerate;
  } scr_out_t;

  typedef struct packed {
    logic signed [SCR_QW-1:0] x;
    logic signed [SCR_QW-1:0] y;
    logic                     cbpz;
  } scr_xy_t;

  typedef enum logic [SCR_CFG_IW-1:0] {
    CFG_ORIGIN_LON = 3'd0,
    CFG_ORIGIN_LAT = 3'd1,
    CFG_POLE_LON   = 3'd2,
    CFG_POLE_LAT   = 3'd3
  } scr_cfg_idx_t;

  // Restoring division of a 64-bit value by a small odd divisor.
  function automatic logic [63:0] div_small(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) as a 64-bit fraction of a turn, from the odd power series.
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    sum = '0;
    if (i == 0) begin
      return SCR_EIGHTH_TURN;
    end
    for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = div_small(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
    end
    prod = {64'd0, sum} * {64'd0, SCR_TWO_OVER_PI};
    return prod[127:64];
  endfunction

endpackage

>>> hw/rtl/scr_rot_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Depends on scr_pkg for the arctangent table.
module scr_rot_cell #(
  parameter int ANGLE_BITS = scr_pkg::SCR_ANGLE_BITS,
  parameter int STAGE      = 0
) (
  input  logic                            clk,
  input  logic signed [scr_pkg::SCR_QW-1:0] x_i,
  input  logic signed [scr_pkg::SCR_QW-1:0] y_i,
  input  logic        [ANGLE_BITS-1:0]      z_i,
  output logic signed [scr_pkg::SCR_QW-1:0] x_o,
  output logic signed [scr_pkg::SCR_QW-1:0] y_o,
  output logic        [ANGLE_BITS-1:0]      z_o
);
  import scr_pkg::*;

  localparam logic [63:0]           ATAN64 = atan_entry(STAGE);
  localparam logic [ANGLE_BITS-1:0] ATAN   = ATAN64[63 -: ANGLE_BITS];

  logic signed [SCR_QW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [ANGLE_BITS-1:0]    z_r, z_nxt;

  always_comb begin
    if (!z_i[ANGLE_BITS-1]) begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> hw/rtl/scr_isqrt_cell.sv
// One cell of the pipelined integer square root: decides one result bit.
// No package dependency.
module scr_isqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic [63:0] r_i,
  input  logic [63:0] v_i,
  output logic [63:0] r_o,
  output logic [63:0] v_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] r_r, v_r, r_nxt, v_nxt, trial;

  always_comb begin
    trial = r_i + BIT;
    if (v_i >= trial) begin
      v_nxt = v_i - trial;
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    v_r <= v_nxt;
  end

  assign r_o = r_r;
  assign v_o = v_r;

endmodule

>>> hw/rtl/scr_vec_cell.sv
// One vectoring-mode CORDIC cell on a normalised 64-bit vector, registered.
// Depends on scr_pkg for the arctangent table.
module scr_vec_cell #(
  parameter int ANGLE_BITS = scr_pkg::SCR_ANGLE_BITS,
  parameter int STAGE      = 0
) (
  input  logic                   clk,
  input  logic signed [63:0]     x_i,
  input  logic signed [63:0]     y_i,
  input  logic [ANGLE_BITS-1:0]  z_i,
  output logic signed [63:0]     x_o,
  output logic signed [63:0]     y_o,
  output logic [ANGLE_BITS-1:0]  z_o
);
  import scr_pkg::*;

  localparam logic [63:0]           ATAN64 = atan_entry(STAGE);
  localparam logic [ANGLE_BITS-1:0] ATAN   = ATAN64[63 -: ANGLE_BITS];

  logic signed [63:0]    x_r, y_r, x_nxt, y_nxt;
  logic [ANGLE_BITS-1:0] z_r, z_nxt;

  always_comb begin
    if (!y_i[63]) begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> hw/rtl/spherical_coordinate_rotation_core.sv
// Spherical coordinate rotation core. Takes one request per clock cycle
// (start high while busy is low; busy is only high just after reset) and
// delivers each result as a single-cycle out_valid strobe. Between request
// and result lie two CORDIC cell chains of CORDIC_STAGES cells each, the
// 32-cell square-root chain and the multiplier and normalisation stages.
// The receiver must take every result in the cycle it is shown. Frame
// registers must be written through the cfg port only while no request is
// in flight; the core leaves this to the user. Depends on scr_pkg, the cell
// modules and assert_macros.svh.
`include "assert_macros.svh"

module spherical_coordinate_rotation_core #(
  parameter int ANGLE_BITS    = scr_pkg::SCR_ANGLE_BITS,
  parameter int CORDIC_STAGES = scr_pkg::SCR_CORDIC_STAGES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  scr_pkg::scr_in_t                  in_data,
  output logic                              out_valid,
  output scr_pkg::scr_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [scr_pkg::SCR_CFG_IW-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata
);
  import scr_pkg::*;

  localparam int N      = CORDIC_STAGES;
  localparam int NL     = 5;
  localparam int ISQ_N  = 32;
  localparam int XY_DLY = ISQ_N - 3;
  localparam int LAT    = 2 * N + 41;
  localparam int NORM_TOP = 59;
  localparam int AB     = ANGLE_BITS;

  // Rotation lanes.
  localparam int LN_B0 = 0;
  localparam int LN_BP = 1;
  localparam int LN_B1 = 2;
  localparam int LN_DA = 3;
  localparam int LN_D0 = 4;

  function automatic logic [AB-1:0] to_ang(input logic [31:0] a);
    logic [63:0] w;
    w = {a, 32'd0};
    return w[63 -: AB];
  endfunction

  function automatic logic signed [SCR_QW-1:0] mulq(input logic signed [SCR_QW-1:0] a,
                                                    input logic signed [SCR_QW-1:0] b);
    logic signed [2*SCR_QW-1:0] prod;
    prod = a * b;
    return prod[SCR_QW+SCR_FRAC-1:SCR_FRAC];
  endfunction

  function automatic logic [5:0] norm_shift(input logic [SCR_QW-1:0] m);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < SCR_QW; i++) begin
      if (m[i]) idx = 6'(i);
    end
    return 6'(NORM_TOP) - idx;
  endfunction

  // ---------------- configuration ----------------
  logic [31:0] origin_lon_r, origin_lat_r, pole_lon_r, pole_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lon_r <= '0;
      origin_lat_r <= '0;
      pole_lon_r   <= '0;
      pole_lat_r   <= 32'h4000_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_LON: origin_lon_r <= cfg_wdata;
        CFG_ORIGIN_LAT: origin_lat_r <= cfg_wdata;
        CFG_POLE_LON:   pole_lon_r   <= cfg_wdata;
        CFG_POLE_LAT:   pole_lat_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- handshake and valid line ----------------
  logic           busy_r, accept;
  logic [LAT:1]   vld_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LAT-1:1], accept};
    end
  end

  // ---------------- angle set-up and quadrant fold ----------------
  logic [AB-1:0] za [NL];
  logic [NL-1:0] flip_nxt;
  logic [AB-1:0] z0_r [NL];
  logic [NL-1:0] flip_r [0:N];

  always_comb begin
    za[LN_B0] = to_ang(origin_lat_r);
    za[LN_BP] = to_ang(pole_lat_r);
    za[LN_B1] = to_ang(in_data.in_latitude);
    za[LN_DA] = to_ang(pole_lon_r) - to_ang(in_data.in_longitude);
    za[LN_D0] = to_ang(pole_lon_r) - to_ang(origin_lon_r);
    for (int l = 0; l < NL; l++) begin
      // Second and third quadrants are folded by half a turn.
      flip_nxt[l] = za[l][AB-1] ^ za[l][AB-2];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      z0_r[l] <= {za[l][AB-1] ^ flip_nxt[l], za[l][AB-2:0]};
    end
    flip_r[0] <= flip_nxt;
    for (int k = 1; k <= N; k++) begin
      flip_r[k] <= flip_r[k-1];
    end
  end

  // ---------------- rotation chains ----------------
  logic signed [SCR_QW-1:0] rx [NL][0:N];
  logic signed [SCR_QW-1:0] ry [NL][0:N];
  logic        [AB-1:0]     rz [NL][0:N];

  for (genvar l = 0; l < NL; l++) begin : g_rot_lane
    assign rx[l][0] = SCR_KINV;
    assign ry[l][0] = '0;
    assign rz[l][0] = z0_r[l];
    for (genvar k = 0; k < N; k++) begin : g_cell
      scr_rot_cell #(.ANGLE_BITS(AB), .STAGE(k)) u_cell (
        .clk (clk),
        .x_i (rx[l][k]),   .y_i (ry[l][k]),   .z_i (rz[l][k]),
        .x_o (rx[l][k+1]), .y_o (ry[l][k+1]), .z_o (rz[l][k+1])
      );
    end
  end

  logic signed [SCR_QW-1:0] s_r [NL];
  logic signed [SCR_QW-1:0] c_r [NL];

  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      s_r[l] <= flip_r[N][l] ? -ry[l][N] : ry[l][N];
      c_r[l] <= flip_r[N][l] ? -rx[l][N] : rx[l][N];
    end
  end

  // ---------------- product stages ----------------
  logic signed [SCR_QW-1:0] t1_1_r, t2_1_r, p_1_r, sbb_1_r, cd_1_r, sbp_1_r, cbp_1_r;
  logic signed [SCR_QW-1:0] sb1_1_r, sb0_1_r;
  logic signed [SCR_QW:0]   sum2;
  logic signed [SCR_QW-1:0] sb2_2_r, p_2_r, sbb_2_r, sbp_2_r, cbp_2_r, sb1_2_r, sb0_2_r;
  logic signed [2*SCR_QW-1:0] sq3;
  logic [63:0]              v_3_r;
  logic signed [SCR_QW-1:0] msb2_3_r, pb_3_r, pbb_3_r, sb1_3_r, sbb_3_r, sb0_3_r, cbp_3_r;
  logic signed [SCR_QW-1:0] q4;
  logic signed [SCR_QW-1:0] qsbb_4_r, qs0_4_r, pbbc_4_r, pb_4_r, cbp_4_r;
  logic signed [SCR_QW-1:0] y_5_r, x2_5_r, qs0_5_r;
  logic                     cbpz_5_r;
  logic signed [SCR_QW-1:0] sb2_dly_r [0:ISQ_N];
  scr_xy_t                  xy_dly_r  [0:XY_DLY];

  always_comb begin
    sum2 = (SCR_QW+1)'(t1_1_r) + (SCR_QW+1)'(mulq(t2_1_r, cd_1_r));
    sq3  = sb2_2_r * sb2_2_r;
    q4   = sb1_3_r - msb2_3_r;
  end

  always_ff @(posedge clk) begin
    t1_1_r  <= mulq(s_r[LN_BP], s_r[LN_B1]);
    t2_1_r  <= mulq(c_r[LN_BP], c_r[LN_B1]);
    p_1_r   <= mulq(s_r[LN_DA], c_r[LN_B1]);
    sbb_1_r <= mulq(s_r[LN_D0], c_r[LN_B0]);
    cd_1_r  <= c_r[LN_DA];
    sbp_1_r <= s_r[LN_BP];
    cbp_1_r <= c_r[LN_BP];
    sb1_1_r <= s_r[LN_B1];
    sb0_1_r <= s_r[LN_B0];

    // sin of the new latitude, clamped to the range -1 to 1.
    if (sum2 > (SCR_QW+1)'(SCR_ONE_Q))       sb2_2_r <= SCR_ONE_Q;
    else if (sum2 < -(SCR_QW+1)'(SCR_ONE_Q)) sb2_2_r <= -SCR_ONE_Q;
    else                                     sb2_2_r <= sum2[SCR_QW-1:0];
    p_2_r   <= p_1_r;
    sbb_2_r <= sbb_1_r;
    sbp_2_r <= sbp_1_r;
    cbp_2_r <= cbp_1_r;
    sb1_2_r <= sb1_1_r;
    sb0_2_r <= sb0_1_r;

    v_3_r        <= (64'd1 << 60) - 64'(sq3);
    msb2_3_r     <= mulq(sb2_2_r, sbp_2_r);
    pb_3_r       <= mulq(p_2_r, sb0_2_r);
    pbb_3_r      <= mulq(p_2_r, sbb_2_r);
    sb1_3_r      <= sb1_2_r;
    sbb_3_r      <= sbb_2_r;
    sb0_3_r      <= sb0_2_r;
    cbp_3_r      <= cbp_2_r;
    sb2_dly_r[0] <= sb2_2_r;

    qsbb_4_r <= mulq(q4, sbb_3_r);
    qs0_4_r  <= mulq(q4, sb0_3_r);
    pbbc_4_r <= mulq(pbb_3_r, cbp_3_r);
    pb_4_r   <= pb_3_r;
    cbp_4_r  <= cbp_3_r;

    y_5_r    <= mulq(pb_4_r - qsbb_4_r, cbp_4_r);
    x2_5_r   <= mulq(pbbc_4_r, cbp_4_r);
    qs0_5_r  <= qs0_4_r;
    cbpz_5_r <= (cbp_4_r == '0);

    xy_dly_r[0].x    <= qs0_5_r + x2_5_r;
    xy_dly_r[0].y    <= y_5_r;
    xy_dly_r[0].cbpz <= cbpz_5_r;

    for (int k = 1; k <= ISQ_N; k++) begin
      sb2_dly_r[k] <= sb2_dly_r[k-1];
    end
    for (int k = 1; k <= XY_DLY; k++) begin
      xy_dly_r[k] <= xy_dly_r[k-1];
    end
  end

  // ---------------- square root chain: cos of the new latitude ----------------
  logic [63:0] sr [0:ISQ_N];
  logic [63:0] sv [0:ISQ_N];

  assign sr[0] = '0;
  assign sv[0] = v_3_r;

  for (genvar k = 0; k < ISQ_N; k++) begin : g_isqrt
    scr_isqrt_cell #(.STEP(k)) u_cell (
      .clk (clk),
      .r_i (sr[k]),   .v_i (sv[k]),
      .r_o (sr[k+1]), .v_o (sv[k+1])
    );
  end

  // ---------------- normalisation for the two arctangents ----------------
  // Lane 0 gives the latitude, lane 1 the longitude.
  logic signed [SCR_QW-1:0] ax [2];
  logic signed [SCR_QW-1:0] ay [2];
  logic signed [SCR_QW-1:0] nx1 [2];
  logic signed [SCR_QW-1:0] ny1 [2];
  logic        [SCR_QW-1:0] aby [2];
  logic signed [SCR_QW-1:0] cb2;
  logic signed [SCR_QW-1:0] nx_r [2];
  logic signed [SCR_QW-1:0] ny_r [2];
  logic        [SCR_QW-1:0] m_r  [2];
  logic [1:0]               neg1_r, neg2_r;
  logic signed [SCR_QW-1:0] sx_r [2];
  logic signed [SCR_QW-1:0] sy_r [2];
  logic [5:0]               sh_r [2];
  logic [2:0]               fl_r [0:N+2];   // {lat zero, lon zero, degenerate}
  logic [2:0]               fl_nxt;

  always_comb begin
    cb2   = $signed(sr[ISQ_N][SCR_QW-1:0]);
    ax[0] = cb2;
    ay[0] = sb2_dly_r[ISQ_N];
    ax[1] = xy_dly_r[XY_DLY].x;
    ay[1] = xy_dly_r[XY_DLY].y;
    for (int l = 0; l < 2; l++) begin
      nx1[l] = ax[l][SCR_QW-1] ? -ax[l] : ax[l];
      ny1[l] = ax[l][SCR_QW-1] ? -ay[l] : ay[l];
      aby[l] = ny1[l][SCR_QW-1] ? SCR_QW'(-ny1[l]) : SCR_QW'(ny1[l]);
    end
    fl_nxt[2] = (ax[0] == '0) && (ay[0] == '0);
    fl_nxt[1] = (ax[1] == '0) && (ay[1] == '0);
    fl_nxt[0] = (cb2 == '0) || xy_dly_r[XY_DLY].cbpz || fl_nxt[1];
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      nx_r[l]   <= nx1[l];
      ny_r[l]   <= ny1[l];
      m_r[l]    <= (SCR_QW'(nx1[l]) > aby[l]) ? SCR_QW'(nx1[l]) : aby[l];
      neg1_r[l] <= ax[l][SCR_QW-1];

      sx_r[l]   <= nx_r[l];
      sy_r[l]   <= ny_r[l];
      sh_r[l]   <= norm_shift(m_r[l]);
      neg2_r[l] <= neg1_r[l];
    end
    fl_r[0] <= fl_nxt;
    for (int k = 1; k <= N + 2; k++) begin
      fl_r[k] <= fl_r[k-1];
    end
  end

  // ---------------- vectoring chains ----------------
  logic signed [63:0] vx [2][0:N];
  logic signed [63:0] vy [2][0:N];
  logic [AB-1:0]      vz [2][0:N];
  logic signed [63:0] vx0_r [2];
  logic signed [63:0] vy0_r [2];
  logic [AB-1:0]      vz0_r [2];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      vx0_r[l] <= 64'(sx_r[l]) <<< sh_r[l];
      vy0_r[l] <= 64'(sy_r[l]) <<< sh_r[l];
      vz0_r[l] <= {neg2_r[l], {(AB-1){1'b0}}};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_vec_lane
    assign vx[l][0] = vx0_r[l];
    assign vy[l][0] = vy0_r[l];
    assign vz[l][0] = vz0_r[l];
    for (genvar k = 0; k < N; k++) begin : g_cell
      scr_vec_cell #(.ANGLE_BITS(AB), .STAGE(k)) u_cell (
        .clk (clk),
        .x_i (vx[l][k]),   .y_i (vy[l][k]),   .z_i (vz[l][k]),
        .x_o (vx[l][k+1]), .y_o (vy[l][k+1]), .z_o (vz[l][k+1])
      );
    end
  end

  // ---------------- rounding and output register ----------------
  logic [63:0]        zw [2];
  logic [31:0]        rnd [2];
  logic signed [31:0] lat;
  scr_out_t           out_r, out_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      zw[l]  = {vz[l][N], {(64-AB){1'b0}}} + 64'h8000_0000;
      rnd[l] = zw[l][63:32];
    end
    lat = fl_r[N+2][2] ? 32'sd0 : $signed(rnd[0]);
    if (lat > 32'sd1073741824)       lat = 32'sd1073741824;
    else if (lat < -32'sd1073741824) lat = -32'sd1073741824;
    out_nxt.out_latitude  = lat;
    out_nxt.out_longitude = fl_r[N+2][0] ? 32'd0 : rnd[1];
    out_nxt.degenerate    = fl_r[N+2][0];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[LAT];
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  `SCR_ASSERT_IMPL(a_result_follows_request, out_valid, $past(start && !busy, LAT))
  `SCR_ASSERT_IMPL(a_degenerate_zero_lon, out_valid && out_data.degenerate, out_data.out_longitude == 32'd0)
  `SCR_ASSERT_IMPL(a_lat_range, out_valid, (out_data.out_latitude <= 32'sd1073741824) && (out_data.out_latitude >= -32'sd1073741824))
  `SCR_ASSERT_NEXT(a_pole_lat_write, cfg_we && (cfg_index == CFG_POLE_LAT), pole_lat_r == $past(cfg_wdata))

endmodule

>>> tb/sv/spherical_coordinate_rotation_core_test.sv
// Self-checking testbench for spherical_coordinate_rotation_core: a queue-fed
// request driver, a result monitor and a bit-exact fixed-point frame-rotation
// predictor. Depends on scr_pkg and the core RTL.
module spherical_coordinate_rotation_core_test;
  import scr_pkg::*;

  localparam int          ANGLE_W   = 32;
  localparam int          N_STAGES  = 30;
  localparam int          ATAN_LEN  = 48;
  localparam int          NUM_REGS  = 4;
  localparam int          PHASES    = 8;
  localparam int          PHASE_LEN = 195;
  localparam int          SETTLE    = 120;
  localparam int          LIMIT     = 400000;
  localparam longint      ONE_Q     = 64'sd1073741824;
  localparam logic [63:0] HALF_TURN = 64'h8000000000000000;
  localparam logic [31:0] QUARTER   = 32'h40000000;
  localparam logic [31:0] MINUS_Q   = 32'hC0000000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  scr_in_t     in_data   = '0;
  logic        out_valid;
  scr_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] origin_lon, origin_lat, pole_lon, pole_lat;
  logic [63:0] atan_tab [ATAN_LEN];
  scr_in_t     pending_requests [$];
  scr_out_t    expected_rotations [$];
  int          mismatches = 0;
  int          cyc = 0;

  spherical_coordinate_rotation_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] snap(input logic [63:0] a);
    return a & ({64{1'b1}} << (64 - ANGLE_W));
  endfunction

  function automatic logic [63:0] widen(input logic [31:0] a);
    return snap({a, 32'h0});
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  task automatic build_atan_table();
    logic [63:0]  sum, term;
    logic [127:0] prod;
    for (int i = 0; i < ATAN_LEN; i++) begin
      if (i == 0) begin
        atan_tab[i] = snap(64'h2000000000000000);
      end else begin
        sum = '0;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        prod = {64'd0, sum} * {64'd0, 64'hA2F9836E4E441529};
        atan_tab[i] = snap(prod[127:64]);
      end
    end
  endtask

  task automatic sin_cos(input logic [63:0] z_in, output longint s, output longint c);
    longint      x, y, nx, ny;
    logic [63:0] z;
    logic        flip;
    x = 652032874;
    y = 0;
    flip = (z_in[63:62] == 2'd1) || (z_in[63:62] == 2'd2);
    z = snap(z_in);
    if (flip) z = z - HALF_TURN;
    for (int i = 0; i < N_STAGES; i++) begin
      if (!z[63]) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_tab[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [63:0] vector_angle(input longint yi, input longint xi);
    logic [63:0] z;
    longint      x, y, m, nx, ny, ay;
    x = xi; y = yi; z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m >= (64'sd1 <<< 60)) begin
      x = x >>> 1; y = y >>> 1; m = m >>> 1;
    end
    while (m < (64'sd1 <<< 59)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    for (int i = 0; i < N_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_tab[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_tab[i];
      end
      x = nx; y = ny;
    end
    return snap(z);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in; r = '0; b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] turn_round(input logic [63:0] z);
    logic [63:0] t;
    t = z + (64'd1 << 31);
    return t[63:32];
  endfunction

  task automatic predict_rotation(input scr_in_t req, output scr_out_t res);
    longint      sb0, cb0, sbp, cbp, sb1, cb1, sd, cd, sp0, cp0;
    longint      sb2, cb2, p, q, sbb, y, x, lat;
    logic [63:0] a1, ap;
    logic [31:0] r;
    logic        degen;
    a1 = widen(req.in_longitude);
    ap = widen(pole_lon);
    sin_cos(widen(origin_lat), sb0, cb0);
    sin_cos(widen(pole_lat), sbp, cbp);
    sin_cos(widen(req.in_latitude), sb1, cb1);
    sin_cos(ap - a1, sd, cd);
    sin_cos(ap - widen(origin_lon), sp0, cp0);
    sb2 = qmul(sbp, sb1) + qmul(qmul(cbp, cb1), cd);
    if (sb2 > ONE_Q) sb2 = ONE_Q;
    if (sb2 < -ONE_Q) sb2 = -ONE_Q;
    cb2 = longint'(int_sqrt(64'(ONE_Q * ONE_Q - sb2 * sb2)));
    r = turn_round(vector_angle(sb2, cb2));
    lat = longint'(signed'(r));
    if (lat > ONE_Q) lat = ONE_Q;
    if (lat < -ONE_Q) lat = -ONE_Q;
    p = qmul(sd, cb1);
    q = sb1 - qmul(sb2, sbp);
    sbb = qmul(sp0, cb0);
    y = qmul(qmul(p, sb0) - qmul(q, sbb), cbp);
    x = qmul(q, sb0) + qmul(qmul(qmul(p, sbb), cbp), cbp);
    degen = (cb2 == 0) || (cbp == 0) || (x == 0 && y == 0);
    res.out_longitude = degen ? 32'd0 : turn_round(vector_angle(y, x));
    res.out_latitude  = lat[31:0];
    res.degenerate    = degen;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cyc, what);
  endtask

  // Driver: a request is taken on an edge where start is high and busy low.
  always @(posedge clk) begin
    scr_out_t res;
    logic     taken, hold, calm;
    cyc <= cyc + 1;
    taken = rst_n && start && !busy;
    if (taken) begin
      predict_rotation(in_data, res);
      expected_rotations.push_back(res);
    end
    hold = start && !taken;
    calm = (cyc % 3000) < 700;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!hold) begin
      if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        start   <= 1'b1;
        in_data <= pending_requests.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    scr_out_t want;
    if (rst_n && out_valid) begin
      if (expected_rotations.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_rotations.pop_front();
        if (out_data.out_longitude !== want.out_longitude)
          report_mismatch($sformatf("longitude %h, predicted %h",
                                    out_data.out_longitude, want.out_longitude));
        if (out_data.out_latitude !== want.out_latitude)
          report_mismatch($sformatf("latitude %h, predicted %h",
                                    out_data.out_latitude, want.out_latitude));
        if (out_data.degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate %b, predicted %b",
                                    out_data.degenerate, want.degenerate));
      end
    end
  end

  always @(posedge clk) begin
    if (cyc > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ORIGIN_LON: origin_lon = val;
      CFG_ORIGIN_LAT: origin_lat = val;
      CFG_POLE_LON:   pole_lon   = val;
      CFG_POLE_LAT:   pole_lat   = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || start || expected_rotations.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_lat();
    return 32'($urandom_range(32'h80000000)) - QUARTER;
  endfunction

  function automatic scr_in_t make_req(input logic [31:0] lon, input logic [31:0] lat);
    scr_in_t r;
    r.in_longitude = lon;
    r.in_latitude  = lat;
    return r;
  endfunction

  initial begin
    int pick;
    build_atan_table();
    origin_lon = '0; origin_lat = '0; pole_lon = '0; pole_lat = QUARTER;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        repeat (SETTLE) @(posedge clk);
        case (ph)
          1: begin
            write_reg(CFG_ORIGIN_LON, 32'hFFFFFFFF);
            write_reg(CFG_ORIGIN_LAT, MINUS_Q);
            write_reg(CFG_POLE_LON, 32'h0);
            write_reg(CFG_POLE_LAT, MINUS_Q);
          end
          2: begin
            write_reg(CFG_ORIGIN_LAT, QUARTER);
            write_reg(CFG_POLE_LON, 32'hFFFFFFFF);
            write_reg(CFG_POLE_LAT, 32'h0);
            // Writes to an index past the register file must change nothing.
            write_reg(3'(NUM_REGS + $urandom_range(NUM_REGS - 1)), $urandom);
          end
          3: begin
            write_reg(CFG_ORIGIN_LON, 32'hBF0A_0000);
            write_reg(CFG_ORIGIN_LAT, 32'h0B2C_0000);
            write_reg(CFG_POLE_LON, 32'h8A2F_0000);
            write_reg(CFG_POLE_LAT, 32'h1CC0_0000);
          end
          default: begin
            write_reg(CFG_ORIGIN_LON, $urandom);
            write_reg(CFG_ORIGIN_LAT, rand_lat());
            write_reg(CFG_POLE_LON, $urandom);
            write_reg(CFG_POLE_LAT, rand_lat());
            write_reg(3'(NUM_REGS + $urandom_range(NUM_REGS - 1)), $urandom);
          end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      if (ph == 0) begin
        pending_requests.push_back(make_req(32'h0, 32'h0));
        pending_requests.push_back(make_req(32'hFFFFFFFF, QUARTER));
        pending_requests.push_back(make_req(32'h80000000, MINUS_Q));
        pending_requests.push_back(make_req(32'h40000000, 32'h0));
        pending_requests.push_back(make_req(32'hC0000000, 32'h20000000));
        pending_requests.push_back(make_req(32'h00000001, 32'hFFFFFFFF));
        pending_requests.push_back(make_req(32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_requests.push_back(make_req(32'h80000001, 32'h80000000));
        pending_requests.push_back(make_req(32'hFFFFFFFF, 32'h40000001));
        pending_requests.push_back(make_req(32'hAAAAAAAA, 32'h55555555));
        pending_requests.push_back(make_req(32'h55555555, 32'hAAAAAAAA));
      end
      // Points at the new pole steer towards the degenerate case.
      pending_requests.push_back(make_req(pole_lon, pole_lat));
      pending_requests.push_back(make_req(origin_lon, origin_lat));
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(99);
        if (pick < 3)
          pending_requests.push_back(make_req(pole_lon, pole_lat));
        else if (pick < 20)
          pending_requests.push_back(make_req($urandom, $urandom));
        else
          pending_requests.push_back(make_req($urandom, rand_lat()));
      end
    end
    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_rotations.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
